// ===== rtl/core/motor_status_frame_receiver_defines.svh =====
// assertion macros used by the checker file
`ifndef MOTOR_STATUS_FRAME_RECEIVER_DEFINES_SVH
`define MOTOR_STATUS_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MSFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define MSFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/msfr_pkg.sv =====
// shared types, constants and crc function for the status frame receiver
package msfr_pkg;

  localparam int FRAME_BYTES   = 10;
  localparam int STORE_BYTES   = FRAME_BYTES - 1;
  localparam int LAST_IDX      = FRAME_BYTES - 1;
  localparam int POS_W         = 4;
  localparam int BITS_PER_BYTE = 8;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  localparam logic [7:0] CRC_POLY          = 8'h31;
  localparam logic [7:0] CRC_INIT          = 8'h00;
  localparam logic [7:0] CRC_TOP           = 8'h80;
  localparam logic [7:0] STATUS_CODE_RESET = 8'd116;

  typedef logic [STORE_BYTES-1:0][7:0] frame_data_t;

  // one finished frame as handed from front to back
  typedef struct packed {
    logic        crc_ok;
    frame_data_t data;
  } frame_rec_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

  // msb-first crc-8 update for one byte, no reflection
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < BITS_PER_BYTE; k++) begin
      if ((c & CRC_TOP) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/motor_status_frame_receiver.sv =====
// Status frame receiver: takes one received byte per cycle on the input channel
// and groups the bytes into fixed 10-byte frames counted from reset, with no
// resynchronisation. A CRC-8 (poly 0x31, init 0, MSB first) over bytes 0 to 8
// is checked against byte 9; the tenth byte of each frame yields one result
// item, via the frame queue and the result register, carrying the decoded
// fields or, on mismatch, a set frame_status with all fields zero. Bytes are
// taken at one per cycle unless stalled; the per-byte CRC update is XOR logic.
// in_stall rises only on the tenth byte, when the two-entry frame queue between
// the framing front and result register is full. cfg_wr_data sets the status
// command code (reset 116) and is to be written only while the block is idle.
module motor_status_frame_receiver import msfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_status,
  output logic [7:0]         out_unit_id,
  output logic [7:0]         out_mode_byte,
  output logic signed [15:0] out_load_current,
  output logic signed [15:0] out_speed_value,
  output logic signed [15:0] out_angle_value,
  output logic [7:0]         out_temperature,
  output logic [7:0]         out_angle_byte,
  output logic               out_has_temperature,
  output logic [7:0]         out_fault_code
);

  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;
  frame_rec_t    push_rec;
  frame_rec_t    head_rec;

  // framing and crc
  msfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_status   (q_status),
    .q_push     (q_push),
    .q_rec      (push_rec)
  );

  // frame queue
  msfr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head_rec (head_rec),
    .status   (q_status)
  );

  // decode and output register
  msfr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .q_status            (q_status),
    .head_rec            (head_rec),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_status    (out_frame_status),
    .out_unit_id         (out_unit_id),
    .out_mode_byte       (out_mode_byte),
    .out_load_current    (out_load_current),
    .out_speed_value     (out_speed_value),
    .out_angle_value     (out_angle_value),
    .out_temperature     (out_temperature),
    .out_angle_byte      (out_angle_byte),
    .out_has_temperature (out_has_temperature),
    .out_fault_code      (out_fault_code)
  );

endmodule

// ===== rtl/core/msfr_front.sv =====
// front end: byte framing, running crc and frame byte store
module msfr_front import msfr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_rx_byte,
  input  queue_status_t q_status,
  output logic          q_push,
  output frame_rec_t    q_rec
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  frame_data_t      store_r;
  logic             last_byte;
  logic             accept;

  // the last byte of a frame needs a free queue slot
  assign last_byte = (pos_r >= POS_W'(LAST_IDX));
  assign in_stall  = last_byte && q_status.full;
  assign accept    = in_valid && !in_stall;

  // finished frame record
  assign q_push      = accept && last_byte;
  assign q_rec.crc_ok = (crc_r == in_rx_byte);
  assign q_rec.data   = store_r;

  // position and crc update
  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (accept) begin
      if (last_byte) begin
        pos_nxt = '0;
        crc_nxt = CRC_INIT;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        crc_nxt = crc8_feed(crc_r, in_rx_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= CRC_INIT;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  // byte store, written before read within each frame
  always_ff @(posedge clk) begin
    if (accept && !last_byte) begin
      store_r[pos_r] <= in_rx_byte;
    end
  end

endmodule

// ===== rtl/core/msfr_queue.sv =====
// two-entry frame queue between front and back
module msfr_queue import msfr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  frame_rec_t    push_rec,
  input  logic          pop,
  output frame_rec_t    head_rec,
  output queue_status_t status
);

  frame_rec_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push;
  logic              do_pop;

  assign status.full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.not_empty = (count_r != '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && status.not_empty;
  assign head_rec = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// ===== rtl/core/msfr_back.sv =====
// back end: field decode and registered result item
module msfr_back import msfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  queue_status_t      q_status,
  input  frame_rec_t         head_rec,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_status,
  output logic [7:0]         out_unit_id,
  output logic [7:0]         out_mode_byte,
  output logic signed [15:0] out_load_current,
  output logic signed [15:0] out_speed_value,
  output logic signed [15:0] out_angle_value,
  output logic [7:0]         out_temperature,
  output logic [7:0]         out_angle_byte,
  output logic               out_has_temperature,
  output logic [7:0]         out_fault_code
);

  logic [7:0]         status_code_r;
  logic               valid_r;
  logic               status_r;
  logic [7:0]         id_r, mode_r, temp_r, abyte_r, fault_r;
  logic signed [15:0] torque_r, speed_r, angle_r;
  logic               has_temp_r;
  logic               load;
  logic               ok;
  logic               has_temp;
  frame_data_t        f;

  // status command code register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_code_r <= STATUS_CODE_RESET;
    end else if (cfg_wr_en) begin
      status_code_r <= cfg_wr_data;
    end
  end

  // take the queue head when the output register is free or leaving
  assign load  = q_status.not_empty && (!valid_r || !out_stall);
  assign q_pop = load;

  assign f        = head_rec.data;
  assign ok       = head_rec.crc_ok;
  assign has_temp = ok && (f[1] == status_code_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  // result payload, zeroed on crc mismatch
  always_ff @(posedge clk) begin
    if (load) begin
      status_r   <= !ok;
      id_r       <= ok ? f[0] : 8'h00;
      mode_r     <= ok ? f[1] : 8'h00;
      torque_r   <= ok ? signed'({f[2], f[3]}) : 16'sd0;
      speed_r    <= ok ? signed'({f[4], f[5]}) : 16'sd0;
      angle_r    <= ok ? signed'({f[6], f[7]}) : 16'sd0;
      temp_r     <= has_temp ? f[6] : 8'h00;
      abyte_r    <= has_temp ? f[7] : 8'h00;
      has_temp_r <= has_temp;
      fault_r    <= ok ? f[8] : 8'h00;
    end
  end

  assign out_valid           = valid_r;
  assign out_frame_status    = status_r;
  assign out_unit_id         = id_r;
  assign out_mode_byte       = mode_r;
  assign out_load_current    = torque_r;
  assign out_speed_value     = speed_r;
  assign out_angle_value     = angle_r;
  assign out_temperature     = temp_r;
  assign out_angle_byte      = abyte_r;
  assign out_has_temperature = has_temp_r;
  assign out_fault_code      = fault_r;

endmodule

// ===== rtl/core/msfr_checker.sv =====
// port-level checker for the status frame receiver, bound to the top level
`include "motor_status_frame_receiver_defines.svh"

module msfr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_frame_status,
  input logic [7:0]         out_unit_id,
  input logic [7:0]         out_mode_byte,
  input logic signed [15:0] out_load_current,
  input logic signed [15:0] out_speed_value,
  input logic signed [15:0] out_angle_value,
  input logic [7:0]         out_temperature,
  input logic [7:0]         out_angle_byte,
  input logic               out_has_temperature,
  input logic [7:0]         out_fault_code
);

  logic fields_zero;

  // every decoded field but the status bytes is zero, with no temperature flag
  assign fields_zero = (out_unit_id == 8'h00) && (out_mode_byte == 8'h00) &&
                       (out_load_current == 16'sd0) && (out_speed_value == 16'sd0) &&
                       (out_angle_value == 16'sd0) && (out_fault_code == 8'h00) &&
                       !out_has_temperature;

  // a stalled result item stays offered
  `MSFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")

  // a crc mismatch carries only zero fields
  `MSFR_ASSERT_NOW(a_bad_zero, out_valid && out_frame_status, fields_zero, "mismatch item has nonzero fields")

  // without temperature the status bytes are zero
  `MSFR_ASSERT_NOW(a_no_temp, out_valid && !out_has_temperature, (out_temperature == 8'h00) && (out_angle_byte == 8'h00), "status bytes set without temperature")

  // with temperature the status bytes mirror the angle word
  `MSFR_ASSERT_NOW(a_temp_match, out_valid && out_has_temperature, (out_temperature == out_angle_value[15:8]) && (out_angle_byte == out_angle_value[7:0]), "status bytes differ from angle word")

endmodule

bind motor_status_frame_receiver msfr_checker u_checker (.*);
